// ===== rtl/dhsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dhsa_pkg: shared types and constants for daily/hourly step accounting
// Command codes, item structs, bucket bank control and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dhsa_pkg;

    localparam int HOURS = 24;                      // hourly buckets kept per day
    localparam logic [14:0] BUCKET_MAX = 15'h7FFF;  // bucket saturation value

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] cumulative;
        logic        time_valid;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_now;
        logic [4:0]  bucket_index;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        today_total;
        logic [14:0]        bucket_steps;
        logic               bucket_valid;
        logic signed [5:0]  current_hour;
        logic [31:0]        revision;
    } out_item_t;

    // Control from the accounting logic to the bucket bank.
    typedef struct packed {
        logic        en;          // apply this update
        logic        clear;       // new day: zero all buckets
        logic        close_en;    // hour change: close the old bucket
        logic [4:0]  close_hour;
        logic [14:0] close_val;
        logic        fill_en;     // write the running bucket
        logic [4:0]  fill_hour;
        logic [14:0] fill_val;
    } bkt_ctrl_t;

    function automatic logic hour_ok(input logic [4:0] h);
        return {1'b0, h} < 6'(HOURS);
    endfunction

    function automatic logic [14:0] sat15(input logic [31:0] d);
        return (|d[31:15]) ? BUCKET_MAX : d[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dhsa_buckets.sv =====
// ----------------------------------------------------------------------------
// dhsa_buckets: hourly bucket bank
// One register lane per hour; clear, close and fill in one pass, read after.
// ----------------------------------------------------------------------------
`default_nettype none

module dhsa_buckets (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dhsa_pkg::bkt_ctrl_t ctrl,
    input  wire logic [4:0]         rd_index,
    output logic [14:0]             rd_data,   // post-update content
    output logic                    changed    // running bucket took a new value
);
    import dhsa_pkg::*;

    logic [14:0] bkt_reg  [HOURS];
    logic [14:0] bkt_next [HOURS];
    logic [HOURS-1:0] chg;

    always_comb begin
        logic [14:0] mid;
        logic        hit;
        for (int i = 0; i < HOURS; i++) begin
            mid = ctrl.clear ? '0 :
                  (ctrl.close_en && ctrl.close_hour == 5'(i)) ? ctrl.close_val : bkt_reg[i];
            hit = ctrl.fill_en && ctrl.fill_hour == 5'(i);
            if (ctrl.en) begin
                bkt_next[i] = hit ? ctrl.fill_val : mid;
                chg[i]      = hit && (ctrl.fill_val != mid);
            end else begin
                bkt_next[i] = bkt_reg[i];
                chg[i]      = 1'b0;
            end
        end
    end

    assign changed = |chg;

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < HOURS; i++) begin
            if (rd_index == 5'(i)) begin
                rd_data = bkt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < HOURS; i++) begin
            if (!aresetn) begin
                bkt_reg[i] <= '0;
            end else begin
                bkt_reg[i] <= bkt_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dhsa_core.sv =====
// ----------------------------------------------------------------------------
// dhsa_core: day and hour accounting state
// Rebases day and hour, drives the bucket bank and forms one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module dhsa_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire dhsa_pkg::in_item_t  item,
    output dhsa_pkg::out_item_t      result
);
    import dhsa_pkg::*;

    logic [31:0] today_reg,     today_next;
    logic [31:0] day_ref_reg,   day_ref_next;
    logic [31:0] hour_ref_reg,  hour_ref_next;
    logic [31:0] rev_reg,       rev_next;
    logic [4:0]  ref_day_reg,   ref_day_next;
    logic [4:0]  fill_hour_reg, fill_hour_next;
    logic        started_reg,   started_next;

    logic        is_upd, timed, new_day, hour_chg, roll;
    logic [31:0] db_min, hb_min, db_fin, hb_fin;
    logic [4:0]  fh_fin;
    logic [14:0] rd_data;
    logic        changed;
    bkt_ctrl_t   bctrl;

    always_comb begin
        is_upd   = item.command == CMD_UPDATE;
        timed    = is_upd && item.time_valid;
        // a count below a baseline pulls that baseline down first
        db_min   = (item.cumulative < day_ref_reg)  ? item.cumulative : day_ref_reg;
        hb_min   = (item.cumulative < hour_ref_reg) ? item.cumulative : hour_ref_reg;
        new_day  = !started_reg || item.day_of_month != ref_day_reg;
        hour_chg = !new_day && item.hour_now != fill_hour_reg;
        roll     = new_day || hour_chg;
        db_fin   = new_day ? item.cumulative : db_min;
        hb_fin   = roll ? item.cumulative : hb_min;
        fh_fin   = roll ? item.hour_now : fill_hour_reg;

        bctrl.en         = step_en && timed;
        bctrl.clear      = new_day;
        bctrl.close_en   = hour_chg && hour_ok(fill_hour_reg);
        bctrl.close_hour = fill_hour_reg;
        bctrl.close_val  = sat15(item.cumulative - hb_min);
        bctrl.fill_en    = hour_ok(fh_fin);
        bctrl.fill_hour  = fh_fin;
        bctrl.fill_val   = sat15(item.cumulative - hb_fin);
    end

    dhsa_buckets u_buckets (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (bctrl),
        .rd_index (item.bucket_index),
        .rd_data  (rd_data),
        .changed  (changed)
    );

    always_comb begin
        today_next     = today_reg;
        day_ref_next   = day_ref_reg;
        hour_ref_next  = hour_ref_reg;
        rev_next       = rev_reg;
        ref_day_next   = ref_day_reg;
        fill_hour_next = fill_hour_reg;
        started_next   = started_reg;
        if (step_en && is_upd) begin
            if (timed) begin
                day_ref_next   = db_fin;
                hour_ref_next  = hb_fin;
                ref_day_next   = new_day ? item.day_of_month : ref_day_reg;
                fill_hour_next = fh_fin;
                started_next   = 1'b1;
                rev_next       = rev_reg + {31'b0, roll} + {31'b0, changed};
                today_next     = item.cumulative - db_fin;
            end else begin
                today_next = item.cumulative;
            end
        end
    end

    always_comb begin
        result.today_total  = today_next;
        result.bucket_valid = started_next && hour_ok(item.bucket_index);
        result.bucket_steps = result.bucket_valid ? rd_data : '0;
        result.current_hour = started_next ? $signed({1'b0, fill_hour_next}) : -6'sd1;
        result.revision     = rev_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            today_reg     <= '0;
            day_ref_reg   <= '0;
            hour_ref_reg  <= '0;
            rev_reg       <= '0;
            ref_day_reg   <= '0;
            fill_hour_reg <= '0;
            started_reg   <= 1'b0;
        end else begin
            today_reg     <= today_next;
            day_ref_reg   <= day_ref_next;
            hour_ref_reg  <= hour_ref_next;
            rev_reg       <= rev_next;
            ref_day_reg   <= ref_day_next;
            fill_hour_reg <= fill_hour_next;
            started_reg   <= started_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/daily_hourly_step_accounting.sv =====
// Timing: an accepted item is held in the input register, then its result is
// registered in the result register and m_tvalid rises with it.
// Throughput: one item per cycle while m_tready does not stall the result; the
// state update and the bucket read are done between the input and result registers.
// Reset (aresetn low, synchronous): all totals, baselines, buckets and the
// revision counter clear to zero, no day is started, both registers empty.
// ----------------------------------------------------------------------------
// daily_hourly_step_accounting: daily and hourly step accounting block
// Takes update and read items on a stream, returns one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module daily_hourly_step_accounting (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // cumulative[31:0], time_valid, day_of_month[4:0],
                                       // hour_now[4:0], bucket_index[4:0]
    input  wire logic        s_tuser,  // command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // today_total[31:0], bucket_steps[14:0],
                                       // bucket_valid, current_hour[5:0],
                                       // revision[31:0], zero pad[1:0]
);
    import dhsa_pkg::*;

    in_item_t  in_item_reg,  in_item_next;
    logic      in_vld_reg,   in_vld_next;
    out_item_t out_item_reg, out_item_next;
    logic      out_vld_reg,  out_vld_next;
    out_item_t result;
    logic      advance;

    // Move the held item through the accounting pass when the result
    // register is empty or being drained this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    // Take a new transfer when the input register is empty or empties in the same cycle.
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next  = in_vld_reg;
        in_item_next = in_item_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next               = 1'b1;
            in_item_next.command      = cmd_t'(s_tuser);
            in_item_next.cumulative   = s_tdata[31:0];
            in_item_next.time_valid   = s_tdata[32];
            in_item_next.day_of_month = s_tdata[37:33];
            in_item_next.hour_now     = s_tdata[42:38];
            in_item_next.bucket_index = s_tdata[47:43];
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    dhsa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Hold the result until the downstream side takes it.
    always_comb begin
        out_vld_next  = out_vld_reg && !m_tready;
        out_item_next = out_item_reg;
        if (advance) begin
            out_vld_next  = 1'b1;
            out_item_next = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00,
                       out_item_reg.revision,
                       out_item_reg.current_hour,
                       out_item_reg.bucket_valid,
                       out_item_reg.bucket_steps,
                       out_item_reg.today_total};

endmodule

`default_nettype wire

// ===== dv/tb_daily_hourly_step_accounting.sv =====
// ----------------------------------------------------------------------------
// tb_daily_hourly_step_accounting: self-checking bench for step accounting
// Drives update and read items through the input stream and predicts every
// result in a small scoreboard that keeps its own day, hour and bucket state.
// It checks each result, field by field, against the oldest prediction.
// A directed run comes first, then random well-formed pedometer traffic with
// some noise. Both sides of the bus stall at random.
// ----------------------------------------------------------------------------

module tb_daily_hourly_step_accounting;
    import dhsa_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the step ledger and holds predicted reports
    // ------------------------------------------------------------------------
    class step_ledger;
        logic [31:0] steps_today;
        logic [31:0] day_ref;
        logic [4:0]  ref_day;
        logic [31:0] hour_ref;
        logic [4:0]  fill_hour;
        logic [14:0] buckets [HOURS];
        logic        started;
        logic [31:0] rev;
        out_item_t   expected_reports [$];
        int          mismatches;

        function new();
            steps_today = '0;
            day_ref     = '0;
            ref_day     = '0;
            hour_ref    = '0;
            fill_hour   = '0;
            foreach (buckets[i]) buckets[i] = '0;
            started    = 1'b0;
            rev        = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function logic [14:0] steps_in_hour(input logic [31:0] d);
            return (d > 32'd32767) ? 15'h7FFF : d[14:0];
        endfunction

        function void apply_update(input logic [31:0] cum, input logic [4:0] day,
                                   input logic [4:0] hour);
            logic [14:0] run;
            // a count that falls under a baseline drags that baseline down
            if (cum < day_ref) day_ref = cum;
            if (cum < hour_ref) hour_ref = cum;
            if (!started || day != ref_day) begin
                // new day, or first trusted date: rebase everything
                day_ref   = cum;
                ref_day   = day;
                started   = 1'b1;
                foreach (buckets[i]) buckets[i] = '0;
                hour_ref  = cum;
                fill_hour = hour;
                rev       = rev + 1;
            end else if (hour != fill_hour) begin
                // hour rollover: freeze the old bucket at its final count
                if (fill_hour < HOURS) buckets[fill_hour] = steps_in_hour(cum - hour_ref);
                hour_ref  = cum;
                fill_hour = hour;
                rev       = rev + 1;
            end
            if (fill_hour < HOURS) begin
                run = steps_in_hour(cum - hour_ref);
                if (run != buckets[fill_hour]) begin
                    buckets[fill_hour] = run;
                    rev = rev + 1;
                end
            end
            steps_today = cum - day_ref;
        endfunction

        // note an accepted input transfer and queue the report it causes
        function void note_input(input in_item_t it);
            out_item_t rpt;
            if (it.command == CMD_UPDATE) begin
                if (!it.time_valid) steps_today = it.cumulative;
                else apply_update(it.cumulative, it.day_of_month, it.hour_now);
            end
            rpt.today_total  = steps_today;
            rpt.bucket_valid = started && (it.bucket_index < HOURS);
            rpt.bucket_steps = rpt.bucket_valid ? buckets[it.bucket_index] : 15'd0;
            rpt.current_hour = started ? {1'b0, fill_hour} : 6'h3F;
            rpt.revision     = rev;
            expected_reports.push_back(rpt);
        endfunction

        function void compare_field(input string what, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected 0x%08h, got 0x%08h", what, exp_v, act_v);
            end
        endfunction

        // check one result transfer against the oldest prediction
        function void check_result(input logic [87:0] d);
            out_item_t rpt;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: 0x%022h", d);
                return;
            end
            rpt = expected_reports.pop_front();
            compare_field("today_total", rpt.today_total, d[31:0]);
            compare_field("bucket_steps", 32'(rpt.bucket_steps), 32'(d[46:32]));
            compare_field("bucket_valid", 32'(rpt.bucket_valid), 32'(d[47]));
            compare_field("current_hour", 32'($unsigned(rpt.current_hour)), 32'(d[53:48]));
            compare_field("revision", rpt.revision, d[85:54]);
            compare_field("pad", 32'd0, 32'(d[87:86]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and bus signals
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // cumulative[31:0], time_valid, day_of_month[4:0],
                                  // hour_now[4:0], bucket_index[4:0]
    logic        s_tuser  = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;         // today_total[31:0], bucket_steps[14:0], bucket_valid,
                                  // current_hour[5:0], revision[31:0], zero pad[1:0]

    // suppress random stalls on both sides while set
    logic        calm = 1'b0;
    int          cycles = 0;
    step_ledger  ledger;

    always #6 aclk = ~aclk;

    daily_hourly_step_accounting uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Hard stop: any hang or lost result ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: check every transfer, then pick the next ready level.
    // Hold ready low through reset; stall at random with a 14 percent chance.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) ledger.check_result(m_tdata);
        m_tready <= aresetn && (calm || $urandom_range(0, 99) >= 14);
    end

    function automatic in_item_t mk(input cmd_t cmd, input logic [31:0] cum,
                                    input logic tv, input logic [4:0] day,
                                    input logic [4:0] hour, input logic [4:0] idx);
        in_item_t it;
        it.command      = cmd;
        it.cumulative   = cum;
        it.time_valid   = tv;
        it.day_of_month = day;
        it.hour_now     = hour;
        it.bucket_index = idx;
        return it;
    endfunction

    // Present one item and hold it until the transfer happens.
    // Drop valid only when an idle gap is taken, so valid never
    // toggles low and high within one time step.
    task automatic send_item(input in_item_t it);
        while (!calm && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {it.bucket_index, it.hour_now, it.day_of_month, it.time_valid,
                     it.cumulative};
        do @(posedge aclk); while (!s_tready);
        ledger.note_input(it);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        in_item_t    directed [$];
        in_item_t    it;
        logic [31:0] cur_cum;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        int          roll;

        ledger = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // read before any trusted date: no bucket, hour reads as -1
        directed.push_back(mk(CMD_READ, 32'h0, 1'b0, 5'd0, 5'd0, 5'd0));
        // untrusted clock: today's total is the raw count, both extremes
        directed.push_back(mk(CMD_UPDATE, 32'hFFFF_FFFF, 1'b0, 5'd3, 5'd4, 5'd0));
        directed.push_back(mk(CMD_UPDATE, 32'h0, 1'b0, 5'd3, 5'd4, 5'd31));
        directed.push_back(mk(CMD_READ, 32'hFFFF_FFFF, 1'b1, 5'd31, 5'd31, 5'd31));
        // first trusted date on day zero still counts as a new day
        directed.push_back(mk(CMD_UPDATE, 32'd1000, 1'b1, 5'd0, 5'd0, 5'd0));
        directed.push_back(mk(CMD_UPDATE, 32'd1500, 1'b1, 5'd0, 5'd0, 5'd0));
        // same count again: no bucket change, revision holds
        directed.push_back(mk(CMD_UPDATE, 32'd1500, 1'b1, 5'd0, 5'd0, 5'd0));
        // hour rollover closes bucket zero
        directed.push_back(mk(CMD_UPDATE, 32'd1600, 1'b1, 5'd0, 5'd1, 5'd0));
        // big jump: bucket saturates
        directed.push_back(mk(CMD_UPDATE, 32'd50000, 1'b1, 5'd0, 5'd1, 5'd1));
        // count under the hour baseline, then under the day baseline
        directed.push_back(mk(CMD_UPDATE, 32'd1200, 1'b1, 5'd0, 5'd1, 5'd1));
        directed.push_back(mk(CMD_UPDATE, 32'd500, 1'b1, 5'd0, 5'd1, 5'd1));
        // hour beyond the bucket range: tracked, never stored
        directed.push_back(mk(CMD_UPDATE, 32'd800, 1'b1, 5'd0, 5'd31, 5'd1));
        directed.push_back(mk(CMD_UPDATE, 32'd900, 1'b1, 5'd0, 5'd31, 5'd23));
        directed.push_back(mk(CMD_READ, 32'd0, 1'b0, 5'd0, 5'd0, 5'd1));
        directed.push_back(mk(CMD_READ, 32'd0, 1'b0, 5'd0, 5'd0, 5'd23));
        // bucket index at and beyond the range
        directed.push_back(mk(CMD_READ, 32'd0, 1'b0, 5'd0, 5'd0, 5'd24));
        directed.push_back(mk(CMD_READ, 32'd0, 1'b0, 5'd0, 5'd0, 5'd31));
        directed.push_back(mk(CMD_UPDATE, 32'd1000, 1'b1, 5'd0, 5'd23, 5'd23));
        // new day near the top of the counter, then wrap down
        directed.push_back(mk(CMD_UPDATE, 32'hFFFF_FFF0, 1'b1, 5'd31, 5'd5, 5'd5));
        directed.push_back(mk(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 5'd31, 5'd5, 5'd5));
        directed.push_back(mk(CMD_UPDATE, 32'd7, 1'b0, 5'd12, 5'd9, 5'd5));
        directed.push_back(mk(CMD_READ, 32'd0, 1'b1, 5'd1, 5'd2, 5'd5));
        directed.push_back(mk(CMD_UPDATE, 32'd0, 1'b1, 5'd31, 5'd5, 5'd5));
        // read with update-looking fields must change nothing
        directed.push_back(mk(CMD_READ, 32'hFFFF_FFFF, 1'b1, 5'd0, 5'd0, 5'd0));
        foreach (directed[i]) send_item(directed[i]);

        // Random part: mostly a plausible pedometer day with random content,
        // plus raw noise items. Run a quiet stretch with no stalls, and once
        // hold off until every prediction has been answered.
        cur_cum  = $urandom;
        cur_day  = 5'($urandom_range(0, 31));
        cur_hour = 5'($urandom_range(0, 23));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 150 && n < 260);
            if (n == 320) begin
                // withdraw the last item so it is not taken twice
                s_tvalid <= 1'b0;
                while (ledger.pending() > 0) @(posedge aclk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                it = mk(cmd_t'($urandom_range(0, 1)), $urandom, 1'($urandom),
                        5'($urandom), 5'($urandom), 5'($urandom));
            end else if (roll < 30) begin
                it = mk(CMD_READ, $urandom, 1'($urandom), 5'($urandom), 5'($urandom),
                        5'($urandom_range(0, 31)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 4)       cur_cum = cur_cum + $urandom_range(30000, 100000);
                else if (roll < 7)  cur_cum = cur_cum - $urandom_range(0, 2000);
                else if (roll < 8)  cur_cum = $urandom;
                else                cur_cum = cur_cum + $urandom_range(0, 400);
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    cur_day  = 5'($urandom_range(0, 31));
                    cur_hour = 5'd0;
                end else if (roll < 6) begin
                    cur_hour = 5'($urandom_range(0, 31));
                end else if (roll < 16) begin
                    cur_hour = (cur_hour >= 5'd23) ? 5'd0 : cur_hour + 5'd1;
                end
                it = mk(CMD_UPDATE, cur_cum, ($urandom_range(0, 99) >= 5), cur_day,
                        cur_hour, 5'($urandom_range(0, 31)));
            end
            send_item(it);
        end

        // Drain: release the bus and wait out the last results.
        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        while (ledger.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dhsa_pkg.sv
rtl/dhsa_buckets.sv
rtl/dhsa_core.sv
rtl/daily_hourly_step_accounting.sv
dv/tb_daily_hourly_step_accounting.sv
